>>> hw/rtl/jnfe_pkg.sv
package jnfe_pkg;

    // Name store size: bytes kept for the change test
    localparam int NAME_BYTES = 64;
    localparam int ADDR_W     = $clog2(NAME_BYTES);

    // Result queue between the compare stage and the output port
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Characters the parser looks for
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // Quoted key text: "name"
    localparam int KEY_LEN = 6;
    localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{8'h22, 8'h6E, 8'h61, 8'h6D, 8'h65, 8'h22};

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
        logic       empty_frame;
    } t_in;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       is_name_byte;
        logic       frame_end;
        logic [7:0] name_length;
        logic       name_changed;
        logic       name_truncated;
    } t_out;

    typedef enum logic [5:0] {
        PH_KEY   = 6'b000001,
        PH_COLON = 6'b000010,
        PH_SPACE = 6'b000100,
        PH_NAME  = 6'b001000,
        PH_ESC   = 6'b010000,
        PH_DONE  = 6'b100000
    } t_phase;

    // Work handed from the parse stage to the compare stage
    typedef struct packed {
        logic              put;
        logic [7:0]        name_byte;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic              cmp;
        logic              frame_end;
        logic [7:0]        length;
        logic              len_diff;
        logic              ovf;
    } t_s1;

endpackage

>>> hw/rtl/jnfe_ram.sv
module jnfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/json_name_field_extractor.sv
// Extracts the value of the first "name" key from a byte stream of JSON
// text, one byte per request, frames delimited by last_byte. Every name byte
// is delivered as its own result, and each frame closes with one summary
// result carrying the saturated length, a changed flag against the previous
// frame's name, and a truncation flag. One input request is taken per clock
// cycle while o_ready is high; results leave at one per cycle while i_ready is
// high, so a frame-closing request releasing a trailing name byte uses two
// output slots. A request's results are registered in the parse stage,
// alongside the registered name-store read, then written to the result queue.
// The first NAME_BYTES name bytes are kept in a single-port-write, one-read
// store; a small result queue absorbs output stalls and ready drops when the
// queue could not take the stage in flight plus two more results.
module json_name_field_extractor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  jnfe_pkg::t_in     i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output jnfe_pkg::t_out    o_data
);

    // ---------------- parse stage state ----------------
    jnfe_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_kcnt, n_kcnt;
    logic [7:0]       r_new_len;
    logic [7:0]       r_stored_len;
    logic             r_ovf;

    // ---------------- compare stage state ----------------
    logic             r_s1_valid;
    jnfe_pkg::t_s1    r_s1, n_s1;
    logic             r_mism;

    // ---------------- result queue ----------------
    jnfe_pkg::t_out                r_fifo [jnfe_pkg::FIFO_DEPTH];
    logic [jnfe_pkg::FIFO_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [jnfe_pkg::FIFO_AW:0]    r_count;

    logic              accept;
    logic              pop;
    logic              take_put;
    logic              put;
    logic [7:0]        put_byte;
    logic              sat;
    logic              in_buf;
    logic [7:0]        len_after;
    logic              ovf_after;
    logic [7:0]        rdata;
    logic              mism_now;
    logic              changed;
    logic [1:0]        push_cnt;
    logic [jnfe_pkg::FIFO_AW-1:0] wr_ptr_nxt;
    logic [jnfe_pkg::FIFO_AW+1:0] credit;
    jnfe_pkg::t_out    byte_res;
    jnfe_pkg::t_out    end_res;

    // Ready while the queue can hold the stage in flight plus two more results
    assign credit  = {1'b0, r_count} + (jnfe_pkg::FIFO_AW + 2)'({r_s1_valid, 1'b0})
                     + (jnfe_pkg::FIFO_AW + 2)'(2);
    assign o_ready = (credit <= (jnfe_pkg::FIFO_AW + 2)'(jnfe_pkg::FIFO_DEPTH));
    assign accept  = i_valid & o_ready;

    // Parser next state for one byte
    always_comb begin
        n_phase  = r_phase;
        n_kcnt   = r_kcnt;
        take_put = 1'b0;
        if (!i_data.empty_frame) begin
            case (r_phase)
                jnfe_pkg::PH_KEY: begin
                    if (i_data.char_byte == jnfe_pkg::KEY_TEXT[r_kcnt]) begin
                        if (r_kcnt == 3'(jnfe_pkg::KEY_LEN - 1)) begin
                            n_kcnt  = 3'd0;
                            n_phase = jnfe_pkg::PH_COLON;
                        end else begin
                            n_kcnt = r_kcnt + 3'd1;
                        end
                    end else begin
                        n_kcnt = (i_data.char_byte == jnfe_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
                    end
                end
                jnfe_pkg::PH_COLON: begin
                    if (i_data.char_byte == jnfe_pkg::CH_COLON) begin
                        n_phase = jnfe_pkg::PH_SPACE;
                    end
                end
                jnfe_pkg::PH_SPACE: begin
                    if (i_data.char_byte == jnfe_pkg::CH_QUOTE) begin
                        n_phase = jnfe_pkg::PH_NAME;
                    end else if (i_data.char_byte != jnfe_pkg::CH_SPACE &&
                                 i_data.char_byte != jnfe_pkg::CH_TAB) begin
                        n_phase = jnfe_pkg::PH_DONE;
                    end
                end
                jnfe_pkg::PH_NAME: begin
                    if (i_data.char_byte == jnfe_pkg::CH_BACKSLASH) begin
                        n_phase = jnfe_pkg::PH_ESC;
                    end else if (i_data.char_byte == jnfe_pkg::CH_QUOTE) begin
                        n_phase = jnfe_pkg::PH_DONE;
                    end else begin
                        take_put = 1'b1;
                    end
                end
                jnfe_pkg::PH_ESC: begin
                    take_put = 1'b1;
                    n_phase  = jnfe_pkg::PH_NAME;
                end
                default: begin
                end
            endcase
        end
    end

    // Name byte for this request: a parsed one, or a pending backslash at frame end
    assign put      = take_put | (i_data.last_byte & (n_phase == jnfe_pkg::PH_ESC));
    assign put_byte = take_put ? i_data.char_byte : jnfe_pkg::CH_BACKSLASH;
    assign sat      = (r_new_len == 8'hFF);
    assign in_buf   = ({1'b0, r_new_len} < 9'(jnfe_pkg::NAME_BYTES));
    assign len_after = (put && !sat) ? (r_new_len + 8'd1) : r_new_len;
    assign ovf_after = r_ovf | (put & (sat | ~in_buf));

    // Work for the compare stage
    always_comb begin
        n_s1.put       = put;
        n_s1.name_byte = put_byte;
        n_s1.wr        = put & ~sat & in_buf;
        n_s1.addr      = r_new_len[jnfe_pkg::ADDR_W-1:0];
        n_s1.cmp       = put & ~sat & in_buf & (r_new_len < r_stored_len);
        n_s1.frame_end = i_data.last_byte;
        n_s1.length    = len_after;
        n_s1.len_diff  = (len_after != r_stored_len);
        n_s1.ovf       = ovf_after;
    end

    // Parse stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= jnfe_pkg::PH_KEY;
            r_kcnt       <= 3'd0;
            r_new_len    <= 8'd0;
            r_stored_len <= 8'd0;
            r_ovf        <= 1'b0;
        end else if (accept) begin
            if (i_data.last_byte) begin
                r_phase      <= jnfe_pkg::PH_KEY;
                r_kcnt       <= 3'd0;
                r_new_len    <= 8'd0;
                r_stored_len <= len_after;
                r_ovf        <= 1'b0;
            end else begin
                r_phase   <= n_phase;
                r_kcnt    <= n_kcnt;
                r_new_len <= len_after;
                r_ovf     <= ovf_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // Name store: read old byte in the parse stage, write new byte after compare.
    // Consecutive name bytes of one frame use consecutive entries, so their read and write never collide.
    jnfe_ram #(
        .WIDTH (8),
        .DEPTH (jnfe_pkg::NAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid & r_s1.wr),
        .i_waddr (r_s1.addr),
        .i_wdata (r_s1.name_byte),
        .i_re    (accept & n_s1.cmp),
        .i_raddr (n_s1.addr),
        .o_rdata (rdata)
    );

    // Compare stage
    assign mism_now = r_s1.cmp & (rdata != r_s1.name_byte);
    assign changed  = r_mism | mism_now | r_s1.len_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mism <= 1'b0;
        end else if (r_s1_valid) begin
            if (r_s1.frame_end) begin
                r_mism <= 1'b0;
            end else if (mism_now) begin
                r_mism <= 1'b1;
            end
        end
    end

    always_comb begin
        byte_res                = '0;
        byte_res.name_byte      = r_s1.name_byte;
        byte_res.is_name_byte   = 1'b1;
        end_res                 = '0;
        end_res.frame_end       = 1'b1;
        end_res.name_length     = r_s1.length;
        end_res.name_changed    = changed;
        end_res.name_truncated  = r_s1.ovf;
    end

    // Result queue
    assign push_cnt   = r_s1_valid ? ({1'b0, r_s1.put} + {1'b0, r_s1.frame_end}) : 2'd0;
    assign wr_ptr_nxt = r_wr_ptr + jnfe_pkg::FIFO_AW'(1);
    assign pop        = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            if (r_s1.put) begin
                r_fifo[r_wr_ptr] <= byte_res;
                if (r_s1.frame_end) begin
                    r_fifo[wr_ptr_nxt] <= end_res;
                end
            end else if (r_s1.frame_end) begin
                r_fifo[r_wr_ptr] <= end_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + jnfe_pkg::FIFO_AW'(push_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + jnfe_pkg::FIFO_AW'(1);
            end
            r_count <= r_count + (jnfe_pkg::FIFO_AW + 1)'(push_cnt)
                       - (jnfe_pkg::FIFO_AW + 1)'(pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_fifo[r_rd_ptr];

endmodule
